### rtl/svfcgp_pkg.sv
package svfcgp_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;

  // integrator width
  localparam int IW     = 32;
  // widest coefficient register
  localparam int COEF_W = 24;

  // coefficient digit handled per cycle by the shared multiplier
  localparam int CHUNK = 8;
  localparam int NCH   = (COEF_W + CHUNK - 1) / CHUNK;
  localparam int CWP   = NCH * CHUNK;
  localparam int CNT_W = $clog2(NCH + 1);

  // multiplicand, full product and scaled product widths
  localparam int AW = IW + 2 * (COEF_W - COEF_FRAC_BITS) + 4;
  localparam int PW = AW + CWP;
  localparam int RW = PW - COEF_FRAC_BITS;

  localparam int NUM_REGS = 7;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam int CFG_W    = 24;

  localparam int MODE_W = 2;
  localparam int G_W    = 24;
  localparam int K_W    = 20;
  localparam int N_W    = 17;
  localparam int GAIN_W = 20;
  localparam int PAN_W  = 17;

  typedef enum logic [MODE_W-1:0] {
    MODE_BYPASS = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2,
    MODE_BAND   = 2'd3
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MODE  = 3'd0,
    REG_G     = 3'd1,
    REG_K     = 3'd2,
    REG_NORM  = 3'd3,
    REG_GAIN  = 3'd4,
    REG_LPAN  = 3'd5,
    REG_RPAN  = 3'd6
  } reg_idx_t;

  localparam logic [G_W-1:0]    RST_G    = G_W'(4295);
  localparam logic [K_W-1:0]    RST_K    = K_W'(92684);
  localparam logic [N_W-1:0]    RST_NORM = N_W'(59742);
  localparam logic [GAIN_W-1:0] RST_GAIN = GAIN_W'(65536);
  localparam logic [PAN_W-1:0]  RST_PAN  = PAN_W'(46341);

  typedef struct packed {
    mode_t               mode;
    logic [G_W-1:0]      g;
    logic [K_W-1:0]      k;
    logic [N_W-1:0]      norm;
    logic [GAIN_W-1:0]   gain;
    logic [PAN_W-1:0]    lpan;
    logic [PAN_W-1:0]    rpan;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mac_sts_t;

  function automatic logic signed [IW-1:0] sat_int(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = $signed({{(RW - IW + 1){1'b0}}, {(IW - 1){1'b1}}});
    lo = $signed({{(RW - IW + 1){1'b1}}, {(IW - 1){1'b0}}});
    if (v > hi) begin
      return hi[IW-1:0];
    end else if (v < lo) begin
      return lo[IW-1:0];
    end
    return v[IW-1:0];
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] hi;
    logic signed [RW-1:0] lo;
    hi = $signed({{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}});
    lo = $signed({{(RW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}});
    if (v > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage

### rtl/svf_channel_gain_pan.sv
// One mixer channel: state variable filter, channel gain and constant-power pan.
// Input channel: in_valid/in_stall with in_sample (signed Q1.23). The block
// raises in_stall while it works on a sample and accepts a new one once idle.
// Output channel: out_valid/out_stall with out_left and out_right (signed
// Q1.23, saturated), held in an output register, so the next sample may be
// taken while a result still waits; a stalled result stays unchanged and the
// block stops before overwriting it.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// write only while the block is idle.
// Sequence: every coefficient product runs on one shared multiplier that takes
// one 8-bit coefficient digit per cycle. A filtered sample needs 6 products (7
// in high-pass), an integrator update step and a hand-off step; bypass needs
// 3 products and the hand-off. A new sample is taken only once the result has
// moved to the output register, which waits while a stalled result is held.
// Reset: the registers take their default values, both integrators clear and
// no result is pending.
module svf_channel_gain_pan (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [svfcgp_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [svfcgp_pkg::SAMPLE_BITS-1:0] out_left,
  output logic signed [svfcgp_pkg::SAMPLE_BITS-1:0] out_right,
  input  logic                                  cfg_we,
  input  logic [svfcgp_pkg::IDX_W-1:0]          cfg_index,
  input  logic [svfcgp_pkg::CFG_W-1:0]          cfg_data
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_MD   = 10'b00_0000_0010,
    ST_MN   = 10'b00_0000_0100,
    ST_MV   = 10'b00_0000_1000,
    ST_UPD  = 10'b00_0001_0000,
    ST_MK   = 10'b00_0010_0000,
    ST_MC   = 10'b00_0100_0000,
    ST_ML   = 10'b00_1000_0000,
    ST_MR   = 10'b01_0000_0000,
    ST_DONE = 10'b10_0000_0000
  } state_t;

  localparam int SB = svfcgp_pkg::SAMPLE_BITS;
  localparam int IW = svfcgp_pkg::IW;
  localparam int AW = svfcgp_pkg::AW;
  localparam int RW = svfcgp_pkg::RW;
  localparam int CWP = svfcgp_pkg::CWP;

  svfcgp_pkg::cfg_t     cfg;
  svfcgp_pkg::mac_sts_t mac_sts;

  logic                     mac_start;
  logic signed [AW-1:0]     mac_a;
  logic [CWP-1:0]           mac_coef;
  logic signed [RW-1:0]     mac_res;

  state_t                   state_r, state_nxt;
  logic signed [SB-1:0]     x_r, x_nxt;
  logic signed [IW-1:0]     ic1_r, ic1_nxt;
  logic signed [IW-1:0]     ic2_r, ic2_nxt;
  logic signed [IW-1:0]     v1_r, v1_nxt;
  logic signed [IW-1:0]     v2_r, v2_nxt;
  logic signed [AW-1:0]     m_r, m_nxt;
  logic signed [SB-1:0]     left_r, left_nxt;
  logic signed [SB-1:0]     right_r, right_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [SB-1:0]     out_left_r, out_left_nxt;
  logic signed [SB-1:0]     out_right_r, out_right_nxt;

  logic                     in_xfer;
  logic                     out_xfer;
  logic signed [RW-1:0]     sum_w;

  svfcgp_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  svfcgp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .a     (mac_a),
    .coef  (mac_coef),
    .sts   (mac_sts),
    .res   (mac_res)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    ic1_nxt       = ic1_r;
    ic2_nxt       = ic2_r;
    v1_nxt        = v1_r;
    v2_nxt        = v2_r;
    m_nxt         = m_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    mac_start     = 1'b0;
    mac_a         = '0;
    mac_coef      = '0;
    sum_w         = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt     = in_sample;
          mac_start = 1'b1;
          if (cfg.mode == svfcgp_pkg::MODE_BYPASS) begin
            mac_a     = AW'(in_sample);
            mac_coef  = CWP'(cfg.gain);
            state_nxt = ST_MC;
          end else begin
            mac_a     = AW'(in_sample) - AW'(ic2_r);
            mac_coef  = CWP'(cfg.g);
            state_nxt = ST_MD;
          end
        end
      end
      ST_MD: begin
        if (mac_sts.done) begin
          sum_w     = mac_res + RW'(ic1_r);
          mac_start = 1'b1;
          mac_a     = AW'(sum_w);
          mac_coef  = CWP'(cfg.norm);
          state_nxt = ST_MN;
        end
      end
      ST_MN: begin
        if (mac_sts.done) begin
          v1_nxt    = svfcgp_pkg::sat_int(mac_res);
          mac_start = 1'b1;
          mac_a     = AW'(v1_nxt);
          mac_coef  = CWP'(cfg.g);
          state_nxt = ST_MV;
        end
      end
      ST_MV: begin
        if (mac_sts.done) begin
          v2_nxt    = svfcgp_pkg::sat_int(mac_res + RW'(ic2_r));
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ic1_nxt   = svfcgp_pkg::sat_int((RW'(v1_r) <<< 1) - RW'(ic1_r));
        ic2_nxt   = svfcgp_pkg::sat_int((RW'(v2_r) <<< 1) - RW'(ic2_r));
        mac_start = 1'b1;
        unique case (cfg.mode)
          svfcgp_pkg::MODE_HIGH: begin
            mac_a     = AW'(v1_r);
            mac_coef  = CWP'(cfg.k);
            state_nxt = ST_MK;
          end
          svfcgp_pkg::MODE_LOW: begin
            mac_a     = AW'(v2_r);
            mac_coef  = CWP'(cfg.gain);
            state_nxt = ST_MC;
          end
          default: begin
            mac_a     = AW'(v1_r);
            mac_coef  = CWP'(cfg.gain);
            state_nxt = ST_MC;
          end
        endcase
      end
      ST_MK: begin
        if (mac_sts.done) begin
          sum_w     = RW'(x_r) - mac_res - RW'(v2_r);
          mac_start = 1'b1;
          mac_a     = AW'(sum_w);
          mac_coef  = CWP'(cfg.gain);
          state_nxt = ST_MC;
        end
      end
      ST_MC: begin
        if (mac_sts.done) begin
          m_nxt     = AW'(mac_res);
          mac_start = 1'b1;
          mac_a     = AW'(mac_res);
          mac_coef  = CWP'(cfg.lpan);
          state_nxt = ST_ML;
        end
      end
      ST_ML: begin
        if (mac_sts.done) begin
          left_nxt  = svfcgp_pkg::sat_smp(mac_res);
          mac_start = 1'b1;
          mac_a     = m_r;
          mac_coef  = CWP'(cfg.rpan);
          state_nxt = ST_MR;
        end
      end
      ST_MR: begin
        if (mac_sts.done) begin
          right_nxt = svfcgp_pkg::sat_smp(mac_res);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = left_r;
          out_right_nxt = right_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ic1_r       <= '0;
      ic2_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ic1_r       <= ic1_nxt;
      ic2_r       <= ic2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    v1_r        <= v1_nxt;
    v2_r        <= v2_nxt;
    m_r         <= m_nxt;
    left_r      <= left_nxt;
    right_r     <= right_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_left_r;
  assign out_right = out_right_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_mac_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mac_sts.done |-> (state_r == ST_MD || state_r == ST_MN || state_r == ST_MV ||
                      state_r == ST_MK || state_r == ST_MC || state_r == ST_ML ||
                      state_r == ST_MR))
    else $error("multiplier finished with no product pending");

  a_idle_mac_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !mac_sts.busy && !mac_sts.done)
    else $error("multiplier busy while sequencer is not waiting on it");

  a_integ_update: assert property (@(posedge clk) disable iff (!rst_n)
    (ic1_r != $past(ic1_r) || ic2_r != $past(ic2_r)) |-> $past(state_r == ST_UPD))
    else $error("integrators changed outside the update step");

endmodule

### rtl/svfcgp_cfg_regs.sv
module svfcgp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [svfcgp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [svfcgp_pkg::CFG_W-1:0]   cfg_data,
  output svfcgp_pkg::cfg_t               cfg
);

  svfcgp_pkg::cfg_t cfg_r;
  svfcgp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (svfcgp_pkg::reg_idx_t'(cfg_index))
        svfcgp_pkg::REG_MODE: begin
          cfg_nxt.mode = svfcgp_pkg::mode_t'(cfg_data[svfcgp_pkg::MODE_W-1:0]);
        end
        svfcgp_pkg::REG_G: begin
          cfg_nxt.g = cfg_data[svfcgp_pkg::G_W-1:0];
        end
        svfcgp_pkg::REG_K: begin
          cfg_nxt.k = cfg_data[svfcgp_pkg::K_W-1:0];
        end
        svfcgp_pkg::REG_NORM: begin
          cfg_nxt.norm = cfg_data[svfcgp_pkg::N_W-1:0];
        end
        svfcgp_pkg::REG_GAIN: begin
          cfg_nxt.gain = cfg_data[svfcgp_pkg::GAIN_W-1:0];
        end
        svfcgp_pkg::REG_LPAN: begin
          cfg_nxt.lpan = cfg_data[svfcgp_pkg::PAN_W-1:0];
        end
        svfcgp_pkg::REG_RPAN: begin
          cfg_nxt.rpan = cfg_data[svfcgp_pkg::PAN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode <= svfcgp_pkg::MODE_BYPASS;
      cfg_r.g    <= svfcgp_pkg::RST_G;
      cfg_r.k    <= svfcgp_pkg::RST_K;
      cfg_r.norm <= svfcgp_pkg::RST_NORM;
      cfg_r.gain <= svfcgp_pkg::RST_GAIN;
      cfg_r.lpan <= svfcgp_pkg::RST_PAN;
      cfg_r.rpan <= svfcgp_pkg::RST_PAN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/svfcgp_mac.sv
module svfcgp_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [svfcgp_pkg::AW-1:0]     a,
  input  logic [svfcgp_pkg::CWP-1:0]           coef,
  output svfcgp_pkg::mac_sts_t                 sts,
  output logic signed [svfcgp_pkg::RW-1:0]     res
);

  logic [svfcgp_pkg::CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                                      done_r, done_nxt;
  logic signed [svfcgp_pkg::AW-1:0]          a_r;
  logic [svfcgp_pkg::CWP-1:0]                c_r, c_nxt;
  logic signed [svfcgp_pkg::PW-1:0]          acc_r, acc_nxt;
  logic signed [svfcgp_pkg::AW+svfcgp_pkg::CHUNK:0] part;

  // one coefficient digit per cycle, most significant first
  assign part = a_r * $signed({1'b0, c_r[svfcgp_pkg::CWP-1 -: svfcgp_pkg::CHUNK]});

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    c_nxt    = c_r;
    acc_nxt  = acc_r;
    if (start) begin
      cnt_nxt = svfcgp_pkg::CNT_W'(svfcgp_pkg::NCH);
      c_nxt   = coef;
      acc_nxt = '0;
    end else if (cnt_r != '0) begin
      acc_nxt  = (acc_r <<< svfcgp_pkg::CHUNK) + svfcgp_pkg::PW'(part);
      c_nxt    = c_r << svfcgp_pkg::CHUNK;
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == svfcgp_pkg::CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    c_r   <= c_nxt;
    acc_r <= acc_nxt;
  end

  assign sts.busy = (cnt_r != '0);
  assign sts.done = done_r;
  // floor of the product over 2^frac
  assign res = acc_r[svfcgp_pkg::PW-1:svfcgp_pkg::COEF_FRAC_BITS];

endmodule

### dv/svf_gain_pan_checker.sv
module svf_gain_pan_checker
  import svfcgp_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_left,
  input  logic signed [SAMPLE_BITS-1:0] out_right,
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  output int unsigned                   fail_count,
  output int unsigned                   pending
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } stereo_t;

  cfg_t    regs;
  longint  bp_state;
  longint  lp_state;
  stereo_t stereo_due[$];

  function automatic longint coef_scale(input longint v, input longint c);
    return (v * c) >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp(input longint v, input int unsigned bits);
    longint hi;
    hi = (longint'(1) << (bits - 1)) - 1;
    if (v > hi) begin
      return hi;
    end
    if (v < -hi - 1) begin
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic stereo_t filter_and_pan(input logic signed [SAMPLE_BITS-1:0] smp);
    longint  x;
    longint  y;
    longint  ic1;
    longint  ic2;
    longint  v1;
    longint  v2;
    longint  m;
    stereo_t r;
    x = smp;
    if (regs.mode == MODE_BYPASS) begin
      y = x;
    end else begin
      ic1 = bp_state;
      ic2 = lp_state;
      v1 = clamp(coef_scale(ic1 + coef_scale(x - ic2, regs.g), regs.norm), IW);
      v2 = clamp(ic2 + coef_scale(v1, regs.g), IW);
      bp_state = clamp(2 * v1 - ic1, IW);
      lp_state = clamp(2 * v2 - ic2, IW);
      case (regs.mode)
        MODE_LOW: begin
          y = v2;
        end
        MODE_HIGH: begin
          y = x - coef_scale(v1, regs.k) - v2;
        end
        default: begin
          y = v1;
        end
      endcase
    end
    m = coef_scale(y, regs.gain);
    r.left  = SAMPLE_BITS'(clamp(coef_scale(m, regs.lpan), SAMPLE_BITS));
    r.right = SAMPLE_BITS'(clamp(coef_scale(m, regs.rpan), SAMPLE_BITS));
    return r;
  endfunction

  always @(posedge clk) begin
    stereo_t want;
    if (!rst_n) begin
      regs.mode = MODE_BYPASS;
      regs.g    = RST_G;
      regs.k    = RST_K;
      regs.norm = RST_NORM;
      regs.gain = RST_GAIN;
      regs.lpan = RST_PAN;
      regs.rpan = RST_PAN;
      bp_state  = 0;
      lp_state  = 0;
      stereo_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (stereo_due.size() == 0) begin
          $error("unexpected result transfer: out_left %0d, out_right %0d",
                 out_left, out_right);
          fail_count++;
        end else begin
          want = stereo_due.pop_front();
          if (out_left !== want.left) begin
            $error("out_left: expected %0d, actual %0d", want.left, out_left);
            fail_count++;
          end
          if (out_right !== want.right) begin
            $error("out_right: expected %0d, actual %0d", want.right, out_right);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE: begin
            regs.mode = mode_t'(cfg_data[MODE_W-1:0]);
          end
          REG_G: begin
            regs.g = cfg_data[G_W-1:0];
          end
          REG_K: begin
            regs.k = cfg_data[K_W-1:0];
          end
          REG_NORM: begin
            regs.norm = cfg_data[N_W-1:0];
          end
          REG_GAIN: begin
            regs.gain = cfg_data[GAIN_W-1:0];
          end
          REG_LPAN: begin
            regs.lpan = cfg_data[PAN_W-1:0];
          end
          REG_RPAN: begin
            regs.rpan = cfg_data[PAN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        stereo_due.push_back(filter_and_pan(in_sample));
      end
    end
    pending <= stereo_due.size();
  end

endmodule

### dv/tb_top.sv
module tb_top;
  import svfcgp_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned RANDOM_PHASES  = 10;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
  localparam logic [IDX_W-1:0] UNUSED_IDX = IDX_W'(NUM_REGS);

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          cfg_we;
  logic [IDX_W-1:0]              cfg_index;
  logic [CFG_W-1:0]              cfg_data;
  int unsigned                   fail_count;
  int unsigned                   pending;
  bit                            quiet;
  bit                            hold_req;

  svf_channel_gain_pan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_left  (out_left),
    .out_right (out_right),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  svf_gain_pan_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_left   (out_left),
    .out_right  (out_right),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 15);
    end
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int w);
    logic [CFG_W-1:0] mask;
    mask = (CFG_W'(1) << w) - 1'b1;
    return (v & mask) | (CFG_W'($urandom()) & ~mask);
  endfunction

  // matched normalization for a given cutoff and damping
  function automatic logic [N_W-1:0] norm_for(input longint g, input longint k);
    return N_W'((longint'(1) << 48) / ((longint'(1) << 32) + g * (g + k)));
  endfunction

  function automatic cfg_t setting(input mode_t mode, input longint g, input longint k,
                                   input longint norm, input longint gain,
                                   input longint lpan, input longint rpan);
    cfg_t s;
    s.mode = mode;
    s.g    = G_W'(g);
    s.k    = K_W'(k);
    s.norm = N_W'(norm);
    s.gain = GAIN_W'(gain);
    s.lpan = PAN_W'(lpan);
    s.rpan = PAN_W'(rpan);
    return s;
  endfunction

  function automatic cfg_t random_setting();
    mode_t  mode;
    longint g;
    longint k;
    mode = mode_t'($urandom_range(3));
    if ($urandom_range(9) < 6) begin
      g = $urandom_range(300, 140000);
      k = $urandom_range(3277, 655360);
      return setting(mode, g, k, norm_for(g, k), $urandom_range(655360),
                     $urandom_range(65536), $urandom_range(65536));
    end
    return setting(mode, $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom());
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(9))
      7: begin
        return SAMPLE_BITS'($signed($urandom_range(0, 255)) - 128);
      end
      8: begin
        return SMP_MAX;
      end
      9: begin
        return SMP_MIN;
      end
      default: begin
        return SAMPLE_BITS'($urandom());
      end
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic load_regs(input cfg_t s);
    write_reg(REG_MODE, with_junk(CFG_W'(s.mode), MODE_W));
    write_reg(REG_G,    with_junk(CFG_W'(s.g), G_W));
    write_reg(REG_K,    with_junk(CFG_W'(s.k), K_W));
    write_reg(REG_NORM, with_junk(CFG_W'(s.norm), N_W));
    write_reg(REG_GAIN, with_junk(CFG_W'(s.gain), GAIN_W));
    write_reg(REG_LPAN, with_junk(CFG_W'(s.lpan), PAN_W));
    write_reg(REG_RPAN, with_junk(CFG_W'(s.rpan), PAN_W));
    // index past the register list must be ignored
    write_reg(UNUSED_IDX, CFG_W'($urandom()));
    cfg_we <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] smp);
    int unsigned gap;
    in_valid  <= 1'b1;
    in_sample <= smp;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n == 0) begin
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("svf_channel_gain_pan regression: fail");
    $finish;
  end

  initial begin
    int unsigned n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_sample = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, bypass
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample('0);
    send_sample(SAMPLE_BITS'(24'h555555));
    send_sample(SAMPLE_BITS'(24'hAAAAAA));
    drain();

    // low-pass with the cutoff coefficient at its top, drives integrators into saturation
    load_regs(setting(MODE_LOW, 24'hFFFFFF, 655360, 65536, 655360, 65536, 0));
    send_sample(SMP_MAX);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample('0);
    drain();

    // high-pass, zero cutoff and lightest damping on saturated integrators
    load_regs(setting(MODE_HIGH, 0, 3277, 65536, 65536, 46341, 46341));
    send_sample(SAMPLE_BITS'(1));
    send_sample(SAMPLE_BITS'(-1));
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample('0);
    drain();

    // band-pass with muted channel gain
    load_regs(setting(MODE_BAND, 20000, 92684, norm_for(20000, 92684), 0, 65536, 65536));
    repeat (4) send_sample(random_sample());
    drain();

    // bypass at full gain, output saturates while integrators hold
    load_regs(setting(MODE_BYPASS, 4295, 92684, 59742, 655360, 65536, 65536));
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SAMPLE_BITS'(1000));
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_regs(random_setting());
      quiet = ($urandom_range(3) == 0);
      if (p == 1) begin
        // receiver holds off while samples keep coming
        quiet    = 1'b1;
        hold_req = 1'b1;
      end
      n = $urandom_range(55, 85);
      repeat (n) send_sample(random_sample());
      drain();
    end

    if (fail_count == 0) begin
      $display("svf_channel_gain_pan regression: pass");
    end else begin
      $display("svf_channel_gain_pan regression: fail");
    end
    $finish;
  end

endmodule

### svf_channel_gain_pan.f
rtl/svfcgp_pkg.sv
rtl/svfcgp_cfg_regs.sv
rtl/svfcgp_mac.sv
rtl/svf_channel_gain_pan.sv
dv/svf_gain_pan_checker.sv
dv/tb_top.sv
